// ===== design/piecewise_linear_interpolator_defines.svh =====
// Assertion macros shared by the checker of the interpolator.
// No dependencies.
`ifndef PIECEWISE_LINEAR_INTERPOLATOR_DEFINES_SVH
`define PIECEWISE_LINEAR_INTERPOLATOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PLI_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("interpolator assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define PLI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("interpolator assertion failed");

`endif

// ===== design/pli_pkg.sv =====
// Types, codes and helpers of the piecewise linear interpolator.
// No dependencies.
package pli_pkg;

    localparam int CNT_W = 4;

    typedef enum logic [1:0] {
        K_NONE,
        K_EXACT,
        K_SEG,
        K_BELOW
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_BELOW = 2'd1,
        ST_ABOVE = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MUL,
        S_PREP,
        S_DIV,
        S_FIN,
        S_OUT
    } t_state;

    // Query word as it travels along the row of cells.
    typedef struct packed {
        logic [15:0] a;
        t_kind       kind;
        logic [15:0] a0;
        logic [15:0] a1;
        logic [15:0] v0;
        logic [15:0] v1;
        logic [15:0] vlast;
    } t_tok;

    function automatic logic [15:0] sat16(input logic signed [18:0] v);
        logic [15:0] r;
        if (v > 19'sd32767) begin
            r = 16'h7fff;
        end else if (v < -19'sd32768) begin
            r = 16'h8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

// ===== design/piecewise_linear_interpolator.sv =====
// Top level of the piecewise linear interpolator: cell row, multiplier and divider.
// Depends on pli_pkg and pli_cell.
//
//  channel   direction  tdata                                    tuser
//  s         in         point_index, angle, voltage (40 bits)    req_type
//  m         out        estimate (16 bits)                       result_status
//  cfg       in         points_in_use (4 bits)                   -
//
// A query walks the row of MAX_POINTS cells, one cell per cycle. A query that falls
// inside a segment then passes through the multiplier and the radix-2 divider
// (set-up with rounding offset, 35 quotient bits, final sum with saturation).
// Any other query goes from the row straight to the output stage, and a query
// on an empty table skips the row. The next word can be taken from the cycle in
// which the result is offered. Reset is synchronous and active low. A result
// waiting in the output register does not stop the next word from being taken; a
// second result that finds it still full waits, and the input stalls with it.
module piecewise_linear_interpolator #(
    parameter int MAX_POINTS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_wdata,    // points_in_use
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,      // [2:0] point_index, [18:3] angle, [34:19] voltage
    input  logic [0:0]  i_s_tuser,      // [0] req_type
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,      // [15:0] estimate
    output logic [1:0]  o_m_tuser       // [1:0] result_status
);
    import pli_pkg::*;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cfg;
    logic [CNT_W-1:0]   w_n;
    t_tok               r_res;
    logic signed [33:0] r_num;
    logic [16:0]        r_da;
    logic [34:0]        r_dvd;
    logic [17:0]        r_den;
    logic [17:0]        r_rem;
    logic               r_neg;
    logic [5:0]         r_cnt;
    logic [15:0]        r_est;
    t_status            r_stat;
    logic               r_mvalid;
    logic [15:0]        r_mdata;
    logic [1:0]         r_muser;

    logic               w_s_acc;
    logic               w_query;
    logic               w_load_out;
    t_tok               w_tok_in;
    t_tok               w_tok [MAX_POINTS+1];
    logic               w_tok_v [MAX_POINTS+1];
    logic [15:0]        w_ang [MAX_POINTS];
    logic [15:0]        w_vol [MAX_POINTS];

    logic signed [16:0] w_dx, w_dv;
    logic signed [33:0] w_prod;
    logic [33:0]        w_mag;
    logic [18:0]        w_rem_sh;
    logic               w_ge;
    logic signed [18:0] w_step;
    logic signed [18:0] w_sum;

    // A count above the table depth counts as the full table.
    assign w_n = (int'(r_cfg) > MAX_POINTS) ? CNT_W'(MAX_POINTS) : r_cfg;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_s_acc    = i_s_tvalid && o_s_tready;
    assign w_query    = w_s_acc && i_s_tuser[0];

    always_comb begin
        w_tok_in       = '0;
        w_tok_in.a     = i_s_tdata[18:3];
        w_tok_in.kind  = K_NONE;
    end

    assign w_tok[0]   = w_tok_in;
    assign w_tok_v[0] = w_query && (w_n != '0);

    for (genvar g = 0; g < MAX_POINTS; g++) begin : g_cell
        logic [15:0] w_nxt_a, w_nxt_v;
        if (g + 1 < MAX_POINTS) begin : g_mid
            assign w_nxt_a = w_ang[g+1];
            assign w_nxt_v = w_vol[g+1];
        end else begin : g_end
            assign w_nxt_a = w_ang[g];
            assign w_nxt_v = w_vol[g];
        end
        pli_cell #(.IDX(g)) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_wr_en      (w_s_acc && !i_s_tuser[0]),
            .i_wr_slot    (i_s_tdata[2:0]),
            .i_wr_angle   (i_s_tdata[18:3]),
            .i_wr_voltage (i_s_tdata[34:19]),
            .i_n          (w_n),
            .i_tok_valid  (w_tok_v[g]),
            .i_tok        (w_tok[g]),
            .i_nxt_angle  (w_nxt_a),
            .i_nxt_voltage(w_nxt_v),
            .o_angle      (w_ang[g]),
            .o_voltage    (w_vol[g]),
            .o_tok_valid  (w_tok_v[g+1]),
            .o_tok        (w_tok[g+1])
        );
    end

    // Segment arithmetic: the product is registered before the divider starts.
    assign w_dx   = $signed({r_res.a[15], r_res.a}) - $signed({r_res.a0[15], r_res.a0});
    assign w_dv   = $signed({r_res.v1[15], r_res.v1}) - $signed({r_res.v0[15], r_res.v0});
    assign w_prod = w_dx * w_dv;
    assign w_mag  = r_num[33] ? 34'(-r_num) : 34'(r_num);

    // One quotient bit per cycle; the dividend shifts out as the quotient shifts in.
    assign w_rem_sh = {r_rem, r_dvd[34]};
    assign w_ge     = w_rem_sh >= {1'b0, r_den};

    assign w_step = r_neg ? -$signed({1'b0, r_dvd[17:0]}) : $signed({1'b0, r_dvd[17:0]});
    assign w_sum  = $signed({{3{r_res.v0[15]}}, r_res.v0}) + w_step;

    assign w_load_out = (r_state == S_OUT) && (!r_mvalid || i_m_tready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_query) begin
                    n_state = (w_n == '0) ? S_OUT : S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_tok_v[MAX_POINTS]) begin
                    n_state = (w_tok[MAX_POINTS].kind == K_SEG) ? S_MUL : S_OUT;
                end
            end
            S_MUL:  n_state = S_PREP;
            S_PREP: n_state = S_DIV;
            S_DIV: begin
                if (r_cnt == 6'd34) begin
                    n_state = S_FIN;
                end
            end
            S_FIN:  n_state = S_OUT;
            S_OUT: begin
                if (w_load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            r_cfg <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_est  <= '0;
                r_stat <= ST_EMPTY;
            end
            S_SCAN: begin
                r_res <= w_tok[MAX_POINTS];
                case (w_tok[MAX_POINTS].kind)
                    K_BELOW: begin
                        r_est  <= w_tok[MAX_POINTS].v0;
                        r_stat <= ST_BELOW;
                    end
                    K_EXACT: begin
                        r_est  <= w_tok[MAX_POINTS].v0;
                        r_stat <= ST_OK;
                    end
                    K_NONE: begin
                        r_est  <= w_tok[MAX_POINTS].vlast;
                        r_stat <= ST_ABOVE;
                    end
                    default: begin
                        r_stat <= ST_OK;
                    end
                endcase
            end
            S_MUL: begin
                r_num <= w_prod;
                r_da  <= 17'($signed({r_res.a1[15], r_res.a1})
                            - $signed({r_res.a0[15], r_res.a0}));
            end
            S_PREP: begin
                r_neg <= r_num[33];
                r_dvd <= {w_mag, 1'b0} + {18'd0, r_da};
                r_den <= {r_da, 1'b0};
                r_rem <= '0;
                r_cnt <= '0;
            end
            S_DIV: begin
                r_rem <= w_ge ? 18'(w_rem_sh - {1'b0, r_den}) : w_rem_sh[17:0];
                r_dvd <= {r_dvd[33:0], w_ge};
                r_cnt <= r_cnt + 6'd1;
            end
            S_FIN: begin
                r_est <= sat16(w_sum);
            end
            default: begin
            end
        endcase
    end

    // Output register: holds a result until the far side takes it.
    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_mdata <= r_est;
            r_muser <= r_stat;
        end
        if (!i_rst_n) begin
            r_mvalid <= 1'b0;
        end else if (w_load_out) begin
            r_mvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_mvalid <= 1'b0;
        end
    end

    assign o_m_tvalid = r_mvalid;
    assign o_m_tdata  = r_mdata;
    assign o_m_tuser  = r_muser;

endmodule

// ===== design/pli_cell.sv =====
// One breakpoint cell of the interpolator's search row.
// Depends on pli_pkg.
module pli_cell #(
    parameter int IDX = 0
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_wr_en,
    input  logic [2:0]                i_wr_slot,
    input  logic [15:0]               i_wr_angle,
    input  logic [15:0]               i_wr_voltage,
    input  logic [pli_pkg::CNT_W-1:0] i_n,
    input  logic                      i_tok_valid,
    input  pli_pkg::t_tok             i_tok,
    input  logic [15:0]               i_nxt_angle,
    input  logic [15:0]               i_nxt_voltage,
    output logic [15:0]               o_angle,
    output logic [15:0]               o_voltage,
    output logic                      o_tok_valid,
    output pli_pkg::t_tok             o_tok
);
    import pli_pkg::*;

    logic [15:0] r_angle;
    logic [15:0] r_voltage;
    logic        r_tok_valid;
    t_tok        r_tok;
    t_tok        w_tok;
    logic        w_in_use;
    logic        w_last;
    logic        w_has_next;

    assign w_in_use   = int'(i_n) > IDX;
    assign w_last     = int'(i_n) == IDX + 1;
    assign w_has_next = int'(i_n) > IDX + 1;

    always_ff @(posedge i_clk) begin
        if (i_wr_en && (IDX < 8) && (int'(i_wr_slot) == IDX)) begin
            r_angle   <= i_wr_angle;
            r_voltage <= i_wr_voltage;
        end
        r_tok <= i_tok;
        if (!i_rst_n) begin
            r_tok_valid <= 1'b0;
        end else begin
            r_tok_valid <= i_tok_valid;
        end
    end

    // The first cell to decide claims the word; after it only vlast may change.
    always_comb begin
        w_tok = r_tok;
        if (r_tok_valid && w_in_use) begin
            if (w_last) begin
                w_tok.vlast = r_voltage;
            end
            if (r_tok.kind == K_NONE) begin
                if ((IDX == 0) && ($signed(r_tok.a) < $signed(r_angle))) begin
                    w_tok.kind = K_BELOW;
                    w_tok.v0   = r_voltage;
                end else if (r_tok.a == r_angle) begin
                    w_tok.kind = K_EXACT;
                    w_tok.v0   = r_voltage;
                end else if (w_has_next && ($signed(r_angle) < $signed(r_tok.a))
                             && ($signed(r_tok.a) < $signed(i_nxt_angle))) begin
                    w_tok.kind = K_SEG;
                    w_tok.a0   = r_angle;
                    w_tok.a1   = i_nxt_angle;
                    w_tok.v0   = r_voltage;
                    w_tok.v1   = i_nxt_voltage;
                end
            end
        end
    end

    assign o_angle     = r_angle;
    assign o_voltage   = r_voltage;
    assign o_tok_valid = r_tok_valid;
    assign o_tok       = w_tok;

endmodule

// ===== design/pli_checker.sv =====
// Port-level checker of the piecewise linear interpolator and its bind.
// Depends on piecewise_linear_interpolator_defines.svh and pli_pkg.
`include "piecewise_linear_interpolator_defines.svh"

module pli_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [0:0]  i_s_tuser,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata,
    input logic [1:0]  o_m_tuser
);
    import pli_pkg::*;

    // A stalled result word holds.
    `PLI_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata))

    // A write word never produces a result.
    `PLI_ASSERT_NEXT(a_wr_silent, i_clk, i_rst_n, i_s_tvalid && o_s_tready && !i_s_tuser[0] && !o_m_tvalid, !o_m_tvalid)

    // The block works on one query at a time.
    `PLI_ASSERT_NEXT(a_one_query, i_clk, i_rst_n, i_s_tvalid && o_s_tready && i_s_tuser[0], !o_s_tready)

    // An empty table answers zero.
    `PLI_ASSERT_SAME(a_empty_zero, i_clk, i_rst_n, o_m_tvalid && (o_m_tuser == ST_EMPTY), o_m_tdata == 16'd0)

endmodule

bind piecewise_linear_interpolator pli_checker u_pli_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_s_tvalid(i_s_tvalid),
    .o_s_tready(o_s_tready),
    .i_s_tuser (i_s_tuser),
    .o_m_tvalid(o_m_tvalid),
    .i_m_tready(i_m_tready),
    .o_m_tdata (o_m_tdata),
    .o_m_tuser (o_m_tuser)
);
